@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL modules; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is low.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ sv/dwspl_pkg.sv @@
// Package of the dual wheel speed loop: constants, operation codes and control structs.
`default_nettype none
package dwspl_pkg;

  localparam int FRAC_BITS_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // Shared multiplier operand widths.
  localparam int MA_W  = 48;
  localparam int MB_W  = 27;
  localparam int PR_W  = MA_W + MB_W;
  localparam int ACC_W = PR_W + 1;

  localparam longint SPEED_Q32 = 64'sd14992264116;
  localparam logic signed [MB_W-1:0] DIST_Q32 = 27'sd2098917;
  localparam logic signed [MB_W-1:0] COEF_A   = 27'sd16747328;
  localparam logic signed [MB_W-1:0] COEF_B   = -27'sd31860770;
  localparam logic signed [MB_W-1:0] COEF_C   = 27'sd15153293;
  localparam logic signed [MB_W-1:0] POLE_Q20 = 27'sd943967;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_WEIGHT = 3'd0;
  localparam logic [2:0] REG_GAIN   = 3'd1;
  localparam logic [2:0] REG_DIST1  = 3'd2;
  localparam logic [2:0] REG_DIST2  = 3'd3;
  localparam logic [2:0] REG_DIST3  = 3'd4;
  localparam logic [2:0] REG_SPEED1 = 3'd5;
  localparam logic [2:0] REG_SPEED2 = 3'd6;
  localparam logic [2:0] REG_SPEED3 = 3'd7;

  localparam logic [15:0] WEIGHT_RST = 16'd4915;
  localparam logic [15:0] GAIN_RST   = 16'd2560;
  localparam logic [31:0] DIST1_RST  = 32'd6553600;
  localparam logic [31:0] DIST2_RST  = 32'd9830400;
  localparam logic [31:0] DIST3_RST  = 32'd19660800;
  localparam logic [23:0] SPEED1_RST = 24'd131072;
  localparam logic [23:0] SPEED2_RST = 24'd327680;
  localparam logic [23:0] SPEED3_RST = 24'd458752;

  typedef enum logic [3:0] {
    OP_NONE, OP_SPEED, OP_MIXW, OP_MIXS, OP_DIST, OP_BAND, OP_ERR,
    OP_CA, OP_CB, OP_CC, OP_GAIN, OP_POLE, OP_PWR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic wheel;
    logic load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

@@ sv/dwspl_if.sv @@
// Handshake interfaces of the input and result channels.
`default_nettype none
interface dwspl_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  modport source (output valid, left_count, right_count, input ready);
  modport sink (input valid, left_count, right_count, output ready);
endinterface

interface dwspl_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] left_power;
  logic signed [7:0] right_power;
  modport source (output valid, left_power, right_power, input ready);
  modport sink (input valid, left_power, right_power, output ready);
endinterface
`default_nettype wire

@@ sv/dwspl_ctrl.sv @@
// Sequencer that steps the shared datapath through one item.
`default_nettype none
`include "assert_macros.svh"
module dwspl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dwspl_pkg::status_t status,
  output dwspl_pkg::cmd_t    cmd
);
  import dwspl_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_SPEED = 14'b00000000000010,
    ST_MIXW  = 14'b00000000000100,
    ST_MIXS  = 14'b00000000001000,
    ST_DIST  = 14'b00000000010000,
    ST_BAND  = 14'b00000000100000,
    ST_ERR   = 14'b00000001000000,
    ST_CA    = 14'b00000010000000,
    ST_CB    = 14'b00000100000000,
    ST_CC    = 14'b00001000000000,
    ST_GAIN  = 14'b00010000000000,
    ST_POLE  = 14'b00100000000000,
    ST_PWR   = 14'b01000000000000,
    ST_OUT   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   wheel_r, wheel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wheel_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wheel_r <= wheel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wheel_nxt = wheel_r;
    cmd.op    = OP_NONE;
    cmd.wheel = wheel_r;
    cmd.load  = 1'b0;
    cmd.emit  = 1'b0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SPEED;
          wheel_nxt = 1'b0;
        end
      end
      ST_SPEED: begin
        cmd.op    = OP_SPEED;
        state_nxt = ST_MIXW;
      end
      ST_MIXW: begin
        cmd.op    = OP_MIXW;
        state_nxt = ST_MIXS;
      end
      ST_MIXS: begin
        cmd.op    = OP_MIXS;
        wheel_nxt = ~wheel_r;
        state_nxt = wheel_r ? ST_DIST : ST_SPEED;
      end
      ST_DIST: begin
        cmd.op    = OP_DIST;
        state_nxt = ST_BAND;
      end
      ST_BAND: begin
        cmd.op    = OP_BAND;
        state_nxt = ST_ERR;
      end
      ST_ERR: begin
        cmd.op    = OP_ERR;
        state_nxt = ST_CA;
      end
      ST_CA: begin
        cmd.op    = OP_CA;
        state_nxt = ST_CB;
      end
      ST_CB: begin
        cmd.op    = OP_CB;
        state_nxt = ST_CC;
      end
      ST_CC: begin
        cmd.op    = OP_CC;
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.op    = OP_GAIN;
        state_nxt = ST_POLE;
      end
      ST_POLE: begin
        cmd.op    = OP_POLE;
        state_nxt = ST_PWR;
      end
      ST_PWR: begin
        cmd.op    = OP_PWR;
        wheel_nxt = ~wheel_r;
        state_nxt = wheel_r ? ST_OUT : ST_ERR;
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        wheel_nxt = 1'b0;
      end
    endcase
  end

  `ASSERT_NXT(a_load_starts, cmd.load, state_r == ST_SPEED && !wheel_r, "load must start wheel A")
  `ASSERT_IMP(a_emit_free, cmd.emit, !status.out_busy, "emit while result register is busy")
  `ASSERT_NXT(a_emit_idle, cmd.emit, in_ready, "block not ready after emitting")

endmodule
`default_nettype wire

@@ sv/dwspl_dp.sv @@
// Datapath: configuration, loop state, shared multiplier and result register.
`default_nettype none
`include "assert_macros.svh"
module dwspl_dp #(
  parameter int FRAC_BITS   = dwspl_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = dwspl_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dwspl_pkg::cmd_t    cmd,
  output dwspl_pkg::status_t status,
  input  logic signed [31:0] in_left_count,
  input  logic signed [31:0] in_right_count,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [7:0]  out_left_power,
  output logic signed [7:0]  out_right_power
);
  import dwspl_pkg::*;

  localparam longint SPEED_QF =
    (SPEED_Q32 + (64'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
  localparam int DSH = 32 - FRAC_BITS;

  logic [15:0] weight_r, gain_r;
  logic [31:0] dlim_r [3];
  logic [23:0] spd_r  [3];

  logic [COUNT_WIDTH-1:0] cur_r  [2];
  logic [COUNT_WIDTH-1:0] last_r [2];
  logic signed [31:0]     smooth_r [2];
  logic signed [31:0]     eh_r [4];
  logic signed [39:0]     dh_r [4];

  logic signed [31:0]      raw_r, err_r;
  logic signed [55:0]      dist_r;
  logic [23:0]             ref_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [7:0]       pend_r [2];
  logic                    out_valid_r;
  logic signed [7:0]       out_left_r, out_right_r;

  logic                   w;
  logic [1:0]             i_new, i_old;
  logic [COUNT_WIDTH-1:0] delta;
  logic signed [32:0]     cur_sum;
  logic signed [40:0]     ydiff;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [PR_W-1:0] prod;
  logic signed [ACC_W-1:0] prod_x, mix_sum, pole_sum, dist_sh;
  logic signed [33:0]     err_raw;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if ((&v[ACC_W-1:31]) || !(|v[ACC_W-1:31])) begin
      return v[31:0];
    end
    return v[ACC_W-1] ? 32'sh80000000 : 32'sh7FFFFFFF;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [ACC_W-1:0] v);
    if ((&v[ACC_W-1:39]) || !(|v[ACC_W-1:39])) begin
      return v[39:0];
    end
    return v[ACC_W-1] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
  endfunction

  // Truncate toward zero to whole percent, then clamp to 100.
  function automatic logic signed [7:0] to_power(input logic signed [39:0] y);
    logic [40:0] mag;
    logic [40:0] m;
    logic [7:0]  m8;
    mag = y[39] ? 41'(-{y[39], y}) : 41'({y[39], y});
    m   = mag >> FRAC_BITS;
    m8  = (m > 41'd100) ? 8'd100 : m[7:0];
    return y[39] ? 8'(-m8) : m8;
  endfunction

  assign w     = cmd.wheel;
  assign i_new = {w, 1'b0};
  assign i_old = {w, 1'b1};
  assign delta = cur_r[w] - last_r[w];
  assign cur_sum = 33'(signed'(cur_r[0])) + 33'(signed'(cur_r[1]));
  assign ydiff = 41'(dh_r[i_new]) - 41'(dh_r[i_old]);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SPEED: begin
        mul_a = MA_W'(signed'(delta));
        mul_b = MB_W'(SPEED_QF);
      end
      OP_MIXW: begin
        mul_a = MA_W'(raw_r);
        mul_b = MB_W'({1'b0, weight_r});
      end
      OP_MIXS: begin
        mul_a = MA_W'(smooth_r[w]);
        mul_b = MB_W'(18'h10000 - {2'b00, weight_r});
      end
      OP_DIST: begin
        mul_a = MA_W'(cur_sum);
        mul_b = DIST_Q32;
      end
      OP_CA: begin
        mul_a = MA_W'(err_r);
        mul_b = COEF_A;
      end
      OP_CB: begin
        mul_a = MA_W'(eh_r[i_new]);
        mul_b = COEF_B;
      end
      OP_CC: begin
        mul_a = MA_W'(eh_r[i_old]);
        mul_b = COEF_C;
      end
      OP_GAIN: begin
        mul_a = acc_r[MA_W+11:12];
        mul_b = MB_W'({1'b0, gain_r});
      end
      OP_POLE: begin
        mul_a = MA_W'(ydiff);
        mul_b = POLE_Q20;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_x   = ACC_W'(prod);
  assign mix_sum  = acc_r + prod_x;
  assign pole_sum = acc_r + (ACC_W'(dh_r[i_new]) <<< 20) + prod_x;
  assign dist_sh  = prod_x >>> DSH;
  assign err_raw  = 34'($signed({10'b0, ref_r})) - 34'(smooth_r[w]);

  assign status.out_busy = out_valid_r && !out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_RST;
      gain_r   <= GAIN_RST;
      dlim_r[0] <= DIST1_RST;
      dlim_r[1] <= DIST2_RST;
      dlim_r[2] <= DIST3_RST;
      spd_r[0]  <= SPEED1_RST;
      spd_r[1]  <= SPEED2_RST;
      spd_r[2]  <= SPEED3_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEIGHT: weight_r  <= cfg_data[15:0];
        REG_GAIN:   gain_r    <= cfg_data[15:0];
        REG_DIST1:  dlim_r[0] <= cfg_data;
        REG_DIST2:  dlim_r[1] <= cfg_data;
        REG_DIST3:  dlim_r[2] <= cfg_data;
        REG_SPEED1: spd_r[0]  <= cfg_data[23:0];
        REG_SPEED2: spd_r[1]  <= cfg_data[23:0];
        REG_SPEED3: spd_r[2]  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Loop state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 2; k++) begin
        last_r[k]   <= '0;
        smooth_r[k] <= '0;
      end
      for (int k = 0; k < 4; k++) begin
        eh_r[k] <= '0;
        dh_r[k] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_MIXS: begin
          smooth_r[w] <= mix_sum[47:16];
          last_r[w]   <= cur_r[w];
        end
        OP_POLE: begin
          eh_r[i_old] <= eh_r[i_new];
          eh_r[i_new] <= err_r;
          dh_r[i_old] <= dh_r[i_new];
          dh_r[i_new] <= sat40(pole_sum >>> 20);
        end
        default: ;
      endcase
    end
  end

  // Working registers of the sequence.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r[0] <= in_left_count[COUNT_WIDTH-1:0];
      cur_r[1] <= in_right_count[COUNT_WIDTH-1:0];
    end
    case (cmd.op)
      OP_SPEED: raw_r <= sat32(prod_x);
      OP_MIXW:  acc_r <= prod_x;
      OP_DIST:  dist_r <= dist_sh[55:0];
      OP_BAND: begin
        if (dist_r < $signed({24'b0, dlim_r[0]})) begin
          ref_r <= spd_r[0];
        end else if (dist_r < $signed({24'b0, dlim_r[1]})) begin
          ref_r <= spd_r[1];
        end else if (dist_r < $signed({24'b0, dlim_r[2]})) begin
          ref_r <= spd_r[2];
        end else begin
          ref_r <= '0;
        end
      end
      OP_ERR:  err_r <= sat32(ACC_W'(err_raw));
      OP_CA:   acc_r <= prod_x;
      OP_CB:   acc_r <= mix_sum;
      OP_CC:   acc_r <= mix_sum;
      OP_GAIN: acc_r <= prod_x;
      OP_PWR:  pend_r[w] <= to_power(dh_r[i_new]);
      default: ;
    endcase
  end

  // Result register: parts the sequence from the receiver.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_left_r  <= pend_r[0];
      out_right_r <= pend_r[1];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_power  = out_left_r;
  assign out_right_power = out_right_r;

  `ASSERT_IMP(a_left_range, out_valid_r, out_left_r >= -8'sd100 && out_left_r <= 8'sd100, "left power out of range")
  `ASSERT_IMP(a_right_range, out_valid_r, out_right_r >= -8'sd100 && out_right_r <= 8'sd100, "right power out of range")

endmodule
`default_nettype wire

@@ sv/dual_wheel_speed_pid_loop.sv @@
// Top level of the dual wheel speed loop: sequencer, datapath and channel wiring.
//
// Each input item carries the absolute encoder counts of the left and right
// wheels for one control tick. The block turns the count deltas into wheel
// speeds, smooths them, picks a reference speed from the travelled distance,
// and runs one filtered-derivative PID step per wheel. Each item yields exactly
// one result item with the left and right motor powers in -100..100.
// All products go through one shared multiplier that the sequencer steps
// through 22 operations, one per cycle. The block takes no new item until
// the result of the last one has moved into the output register.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls, the finished second result holds in the
// datapath until the output register frees up, and input stays blocked.
// The configuration port writes one register per cycle when cfg_we is high;
// write only while the block is idle. Reset (rst_n low, synchronous) loads
// the register defaults, clears all wheel history and drops out_ch.valid.
`default_nettype none
module dual_wheel_speed_pid_loop #(
  parameter int FRAC_BITS   = dwspl_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH = dwspl_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  dwspl_in_if.sink    in_ch,
  dwspl_out_if.source out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dwspl_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The sequencer owns the handshake on the input side.
  dwspl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // The datapath owns the result register and the configuration.
  dwspl_dp #(
    .FRAC_BITS   (FRAC_BITS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_left_count   (in_ch.left_count),
    .in_right_count  (in_ch.right_count),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_left_power  (out_ch.left_power),
    .out_right_power (out_ch.right_power)
  );

endmodule
`default_nettype wire

@@ verif/dwspl_tb_if.sv @@
// Testbench copy note: interfaces come from the RTL; this file holds the wheel-loop scoreboard class.
package dwspl_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  import dwspl_pkg::*;

  localparam longint SPEED_SCALE = 64'sd14992264116;
  localparam longint DIST_SCALE  = 64'sd2098917;
  localparam longint TAP_NOW     = 64'sd16747328;
  localparam longint TAP_PREV    = -64'sd31860770;
  localparam longint TAP_OLDER   = 64'sd15153293;
  localparam longint POLE_COEF   = 64'sd943967;

  class wheel_loop_scoreboard;
    logic [15:0] weight, gain;
    logic [31:0] dist_lim [3];
    logic [23:0] band_speed [3];
    logic [31:0] prev_count [2];
    logic signed [31:0] wheel_speed [2];
    logic signed [31:0] err_hist [4];
    longint drive_hist [4];
    logic [15:0] pending_powers [$];
    int errors;

    function new();
      weight = 16'd4915;
      gain = 16'd2560;
      dist_lim[0] = 32'd6553600;
      dist_lim[1] = 32'd9830400;
      dist_lim[2] = 32'd19660800;
      band_speed[0] = 24'd131072;
      band_speed[1] = 24'd327680;
      band_speed[2] = 24'd458752;
      foreach (prev_count[i]) prev_count[i] = '0;
      foreach (wheel_speed[i]) wheel_speed[i] = '0;
      foreach (err_hist[i]) err_hist[i] = '0;
      foreach (drive_hist[i]) drive_hist[i] = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_WEIGHT: weight = val[15:0];
        REG_GAIN:   gain = val[15:0];
        REG_DIST1:  dist_lim[0] = val;
        REG_DIST2:  dist_lim[1] = val;
        REG_DIST3:  dist_lim[2] = val;
        REG_SPEED1: band_speed[0] = val[23:0];
        REG_SPEED2: band_speed[1] = val[23:0];
        REG_SPEED3: band_speed[2] = val[23:0];
        default: ;
      endcase
    endfunction

    // Saturates v to the signed range of a w-bit value.
    function longint clamp(longint v, int w);
      longint hi;
      hi = (64'sd1 <<< (w - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function logic [7:0] power_of(longint y);
      longint m;
      m = ((y < 0) ? -y : y) >>> 16;
      if (m > 100) m = 100;
      return (y < 0) ? 8'(-m) : 8'(m);
    endfunction

    function logic [7:0] pid_step(int wh, longint e);
      longint s, acc, y1, y0, y;
      y1 = drive_hist[2*wh];
      y0 = drive_hist[2*wh+1];
      s = TAP_NOW * e + TAP_PREV * longint'(err_hist[2*wh])
          + TAP_OLDER * longint'(err_hist[2*wh+1]);
      acc = longint'({48'd0, gain}) * (s >>> 12);
      acc += y1 * (64'sd1 <<< 20) + POLE_COEF * (y1 - y0);
      y = clamp(acc >>> 20, 40);
      err_hist[2*wh+1] = err_hist[2*wh];
      err_hist[2*wh] = 32'(e);
      drive_hist[2*wh+1] = y1;
      drive_hist[2*wh] = y;
      return power_of(y);
    endfunction

    // Notes one accepted tick and queues the expected motor powers.
    function void note_tick(logic signed [31:0] cnt [2]);
      longint step, d, raw, mix, travel, refv, w;
      logic [7:0] pw [2];
      step = (SPEED_SCALE + (64'sd1 <<< 15)) >>> 16;
      w = longint'({48'd0, weight});
      for (int k = 0; k < 2; k++) begin
        d = longint'($signed(cnt[k] - prev_count[k]));
        raw = clamp(d * step, 32);
        mix = w * raw + (64'sd65536 - w) * longint'(wheel_speed[k]);
        wheel_speed[k] = 32'(mix >>> 16);
        prev_count[k] = cnt[k];
      end
      travel = ((longint'(cnt[0]) + longint'(cnt[1])) * DIST_SCALE) >>> 16;
      if (travel < longint'({32'd0, dist_lim[0]})) refv = band_speed[0];
      else if (travel < longint'({32'd0, dist_lim[1]})) refv = band_speed[1];
      else if (travel < longint'({32'd0, dist_lim[2]})) refv = band_speed[2];
      else refv = 0;
      for (int k = 0; k < 2; k++)
        pw[k] = pid_step(k, clamp(refv - longint'(wheel_speed[k]), 32));
      pending_powers.push_back({pw[0], pw[1]});
    endfunction

    // Prints one mismatch line and counts it.
    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic [7:0] lp, logic [7:0] rp);
      logic [15:0] exp_p;
      if (pending_powers.size() == 0) begin
        report($sformatf("unexpected result %0d %0d", $signed(lp), $signed(rp)));
        return;
      end
      exp_p = pending_powers.pop_front();
      if (lp !== exp_p[15:8]) begin
        report($sformatf("left_power got %0d want %0d", $signed(lp), $signed(exp_p[15:8])));
      end
      if (rp !== exp_p[7:0]) begin
        report($sformatf("right_power got %0d want %0d", $signed(rp), $signed(exp_p[7:0])));
      end
    endtask
  endclass
endpackage

@@ verif/dual_wheel_speed_pid_loop_tb.sv @@
// Self-checking testbench of the dual wheel speed loop with random traffic and stalls.
module dual_wheel_speed_pid_loop_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dwspl_pkg::*;
  import dwspl_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_WEIGHT;
  logic [31:0] cfg_data = '0;
  longint cycle_count = 0;
  int sink_stall_mode = 0;

  dwspl_in_if in_ch ();
  dwspl_out_if out_ch ();

  wheel_loop_scoreboard tick_board = new();

  dual_wheel_speed_pid_loop u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // The run is cut off if something hangs; the slowest correct run is far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2000000) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: stalls follow a mode that changes between phases, including no stalls at all.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (sink_stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        2: out_ch.ready <= ($urandom_range(0, 3) == 0);
        default: out_ch.ready <= (cycle_count % 37) > 20;
      endcase
      if (out_ch.valid && out_ch.ready)
        tick_board.check_result(out_ch.left_power, out_ch.right_power);
    end
  end

  // Offers one tick of encoder counts and holds it until the block takes it. Valid
  // stays high afterwards so that the next tick can follow directly; the idle tasks
  // drop it.
  task automatic send_tick(logic [31:0] left_cnt, logic [31:0] right_cnt);
    logic signed [31:0] cnt [2];
    in_ch.valid <= 1'b1;
    in_ch.left_count <= left_cnt;
    in_ch.right_count <= right_cnt;
    cnt[0] = left_cnt;
    cnt[1] = right_cnt;
    do @(posedge clk); while (!in_ch.ready);
    tick_board.note_tick(cnt);
  endtask

  task automatic idle_cycles(int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Waits until every expected result has arrived, plus a margin for the pipeline.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tick_board.pending_powers.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // One write with cfg_we high, then cfg_we drops again before the next write starts.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tick_board.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Wheels that actually roll: counts move by small random steps with rare random jumps,
  // so the distance sweeps through the bands and the loop reaches deep states.
  task automatic rolling_phase(int n, int step_max);
    logic [31:0] l, r;
    int burst;
    l = tick_board.prev_count[0];
    r = tick_board.prev_count[1];
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        if ($urandom_range(0, 15) == 0) begin
          l = $urandom();
          r = $urandom();
        end else begin
          l = l + $urandom_range(0, step_max) - step_max / 4;
          r = r + $urandom_range(0, step_max) - step_max / 4;
        end
        send_tick(l, r);
        n--;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 60));
    end
  endtask

  task automatic random_config();
    write_reg(REG_WEIGHT, $urandom_range(0, 3) == 0 ? 32'hFFFF : $urandom_range(0, 65535));
    write_reg(REG_GAIN, $urandom_range(0, 3) == 0 ? 32'hFFFF : $urandom_range(0, 65535));
    write_reg(REG_DIST1, $urandom_range(0, 30000000));
    write_reg(REG_DIST2, $urandom_range(0, 30000000));
    write_reg(REG_DIST3, $urandom_range(0, 3) == 0 ? 32'hFFFF_FFFF : $urandom_range(0, 40000000));
    write_reg(REG_SPEED1, $urandom_range(0, 24'hFFFFFF));
    write_reg(REG_SPEED2, $urandom_range(0, 24'hFFFFFF));
    write_reg(REG_SPEED3, $urandom_range(0, 24'hFFFFFF));
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.left_count <= '0;
    in_ch.right_count <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed ticks at default settings: standing still, extreme counts, count wrap
    // both ways, saturated speeds and negative distance.
    sink_stall_mode <= 0;
    send_tick(32'd0, 32'd0);
    send_tick(32'd100, 32'd100);
    send_tick(32'h7FFF_FFFF, 32'h8000_0000);
    send_tick(32'h8000_0000, 32'h7FFF_FFFF);
    send_tick(32'hFFFF_FFFF, 32'd1);
    send_tick(32'd2000, 32'd2000);
    send_tick(32'd5000, 32'd5000);
    send_tick(32'd9000, 32'd9000);
    send_tick(32'hFFFF_0000, 32'hFFFF_0000);
    send_tick(32'h5555_5555, 32'hAAAA_AAAA);
    send_tick(32'hAAAA_AAAA, 32'h5555_5555);
    drain();

    // Extreme settings: weight and gain at both ends, limits out of order.
    write_reg(REG_WEIGHT, 32'hFFFF);
    write_reg(REG_GAIN, 32'hFFFF);
    write_reg(REG_DIST1, 32'hFFFF_FFFF);
    write_reg(REG_DIST2, 32'd0);
    write_reg(REG_DIST3, 32'hFFFF_FFFF);
    write_reg(REG_SPEED1, 32'hFF_FFFF);
    write_reg(REG_SPEED2, 32'd0);
    write_reg(REG_SPEED3, 32'hFF_FFFF);
    send_tick(32'd0, 32'd0);
    send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_tick(32'h8000_0000, 32'h8000_0000);
    send_tick(32'd10, 32'd20);
    drain();
    write_reg(REG_WEIGHT, 32'd0);
    write_reg(REG_GAIN, 32'd0);
    write_reg(REG_SPEED1, 32'd0);
    send_tick(32'd50, 32'd60);
    send_tick(32'hFFFF_FFF0, 32'd3);
    drain();

    // Back to defaults for rolling traffic, then several random settings with
    // changing receiver behavior.
    write_reg(REG_WEIGHT, 32'd4915);
    write_reg(REG_GAIN, 32'd2560);
    write_reg(REG_DIST1, 32'd6553600);
    write_reg(REG_DIST2, 32'd9830400);
    write_reg(REG_DIST3, 32'd19660800);
    write_reg(REG_SPEED1, 32'd131072);
    write_reg(REG_SPEED2, 32'd327680);
    write_reg(REG_SPEED3, 32'd458752);
    sink_stall_mode <= 1;
    rolling_phase(300, 40);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      random_config();
      sink_stall_mode <= ph % 4;
      rolling_phase(200, (ph % 2) ? 4000 : 30);
      drain();
    end

    if (tick_board.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
